// ----- hdl/otra_pkg.sv -----
// ----------------------------------------------------------------------------
// Trace ring allocator package
// Field widths, request codes and status codes shared by the ring allocator.
// ----------------------------------------------------------------------------
package otra_pkg;

   // Request fields.
   localparam int REQ_TYPE_W   = 2;
   localparam int BYTES_W      = 16;
   localparam int KIND_W       = 8;
   localparam int REQ_DATA_W   = 24;

   // Result fields.
   localparam int SLOT_W       = 10;
   localparam int HELD_W       = 11;
   localparam int DROP_W       = 11;
   localparam int TOTAL_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int RSP_DATA_W   = 72;

   // A record length in words never needs more than one bit above the byte count.
   localparam int WORDS_W      = BYTES_W + 1;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

endpackage

// ----- hdl/otra_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module otra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/overwriting_trace_ring_allocator.sv -----
// ----------------------------------------------------------------------------
// Overwriting trace ring allocator
// Allocates variable-length records in a ring of words, dropping the oldest.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on req_ carries an allocate, pop or read of the oldest record.
// Every request gives exactly one response beat on rsp_. Kinds and lengths
// live in two RAMs with a registered read; the sequencer reads, updates the
// ring pointers and writes back one entry at a time. An accepted allocate
// takes longer when the ring wraps and for each old record it drops. One
// request is in work at a time and req_tready returns in the same cycle that
// the response loads; the per-record drop loop through the length and kind
// RAMs sets the rate of a long allocate. After reset the kind RAM is swept
// to zero, one word per cycle, and req_tready stays low until the sweep is
// done. A response waiting on a stalled receiver is held in the output
// register; the next request is still accepted and processed, and its
// response waits until the output register frees up.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_allocator
   import otra_pkg::*;
#(
   parameter int RING_WORDS = 1024,
   parameter int WORD_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // alloc_bytes[15:0], entry_kind[23:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [REQ_TYPE_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot_address[9:0], front_kind[17:10], entries_held[28:18],
   // dropped_now[39:29], dropped_total[71:40]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int PW = $clog2(RING_WORDS);
   localparam int CW = $clog2(RING_WORDS + 1);
   localparam int SW = WORDS_W + 1;

   // Words per record = (bytes + WORD_BYTES) / WORD_BYTES, done as a multiply by a
   // rounded-up reciprocal, exact for a numerator below 2**WORDS_W.
   localparam int DIV_SHIFT = WORDS_W + $clog2(WORD_BYTES);
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam longint unsigned DIV_MULT = (64'd1 << DIV_SHIFT) / WORD_BYTES + 1;
   localparam int PROD_W    = WORDS_W + MULT_W;

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_DIV      = 11'b000_0000_0100,
      S_ACHK     = 11'b000_0000_1000,
      S_EVAL     = 11'b000_0001_0000,
      S_POP_LEN  = 11'b000_0010_0000,
      S_POP_NEXT = 11'b000_0100_0000,
      S_POP_TAG  = 11'b000_1000_0000,
      S_COMMIT   = 11'b001_0000_0000,
      S_FRONT    = 11'b010_0000_0000,
      S_OUT      = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      M_POP  = 2'd0,
      M_WRAP = 2'd1,
      M_FIT  = 2'd2
   } mode_type;

   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic [PW-1:0]           rp_ff, rp_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [CW-1:0]           dropped_ff, dropped_in;
   logic [PW-1:0]           clr_ff, clr_in;
   logic [REQ_TYPE_W-1:0]   type_ff, type_in;
   logic [BYTES_W-1:0]      bytes_ff, bytes_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [WORDS_W-1:0]      words_ff, words_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [PW-1:0]           slot_ff, slot_in;
   logic [PW-1:0]           next_ff, next_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic                    tag_we;
   logic [PW-1:0]           tag_wa;
   logic [KIND_W-1:0]       tag_wd;
   logic [PW-1:0]           tag_ra;
   logic [KIND_W-1:0]       tag_rd;
   logic                    len_we;
   logic [CW-1:0]           len_rd;

   logic                    req_fire;
   logic [WORDS_W-1:0]      numer;
   logic [PROD_W-1:0]       product;
   logic [SW-1:0]           next_sum;
   logic [SW-1:0]           alloc_end;
   logic [SW-1:0]           used;
   logic                    count_zero;
   logic [PW-1:0]           slot_out;
   logic [KIND_W-1:0]       front_out;

   otra_ram #(.WIDTH(KIND_W), .DEPTH(RING_WORDS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (tag_wd),
      .rd_addr (tag_ra),
      .rd_data (tag_rd)
   );

   // The length of the oldest record is always read at the read pointer.
   otra_ram #(.WIDTH(CW), .DEPTH(RING_WORDS)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (wp_ff),
      .wr_data (CW'(words_ff)),
      .rd_addr (rp_ff),
      .rd_data (len_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign count_zero = (count_ff == '0);

   assign numer   = WORDS_W'(bytes_ff) + WORDS_W'(WORD_BYTES);
   assign product = PROD_W'(numer) * PROD_W'(MULT_W'(DIV_MULT));

   assign next_sum  = SW'(rp_ff) + SW'(len_rd);
   assign alloc_end = SW'(wp_ff) + SW'(words_ff);

   // Used space runs from the read to the write pointer, wrap gap included.
   always_comb begin
      if (count_zero) begin
         used = '0;
      end else if (wp_ff > rp_ff) begin
         used = SW'(wp_ff) - SW'(rp_ff);
      end else begin
         used = SW'(RING_WORDS) - SW'(rp_ff) + SW'(wp_ff);
      end
   end

   assign slot_out  = (type_ff == REQ_ALLOC) ? slot_ff : rp_ff;
   assign front_out = count_zero ? '0 : tag_rd;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      dropped_in    = dropped_ff;
      clr_in        = clr_ff;
      type_in       = type_ff;
      bytes_in      = bytes_ff;
      kind_in       = kind_ff;
      words_in      = words_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      next_in       = next_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      tag_we        = 1'b0;
      tag_wa        = wp_ff;
      tag_wd        = '0;
      tag_ra        = rp_ff;
      len_we        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            tag_we = 1'b1;
            tag_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PW'(RING_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               type_in    = req_tuser;
               bytes_in   = req_tdata[BYTES_W-1:0];
               kind_in    = req_tdata[BYTES_W +: KIND_W];
               dropped_in = '0;
               status_in  = ST_OK;
               case (req_tuser)
                  REQ_ALLOC: begin
                     state_in = S_DIV;
                  end
                  REQ_POP: begin
                     mode_in = M_POP;
                     if (count_zero) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FRONT;
                     end else begin
                        state_in = S_POP_LEN;
                     end
                  end
                  default: begin
                     if (count_zero) begin
                        status_in = ST_EMPTY;
                     end
                     state_in = S_FRONT;
                  end
               endcase
            end
         end
         S_DIV: begin
            words_in = product[DIV_SHIFT +: WORDS_W];
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (SW'(words_ff) > SW'(RING_WORDS) || kind_ff == '0) begin
               status_in = ST_TOO_LARGE;
               slot_in   = wp_ff;
               state_in  = S_FRONT;
            end else begin
               if (count_zero) begin
                  rp_in = wp_ff;
               end
               mode_in  = (alloc_end > SW'(RING_WORDS)) ? M_WRAP : M_FIT;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (mode_ff)
               M_WRAP: begin
                  if (!count_zero && rp_ff >= wp_ff) begin
                     dropped_in = dropped_ff + 1'b1;
                     total_in   = total_ff + 1'b1;
                     state_in   = S_POP_LEN;
                  end else begin
                     // Mark the tail as the end of the ring and restart at word 0.
                     if (count_zero) begin
                        rp_in = '0;
                     end
                     tag_we  = 1'b1;
                     tag_wa  = wp_ff;
                     wp_in   = '0;
                     mode_in = M_FIT;
                  end
               end
               M_FIT: begin
                  if (!count_zero && (SW'(RING_WORDS) - used) < SW'(words_ff)) begin
                     dropped_in = dropped_ff + 1'b1;
                     total_in   = total_ff + 1'b1;
                     state_in   = S_POP_LEN;
                  end else begin
                     state_in = S_COMMIT;
                  end
               end
               default: begin
                  state_in = S_FRONT;
               end
            endcase
         end
         S_POP_LEN: begin
            state_in = S_POP_NEXT;
         end
         S_POP_NEXT: begin
            next_in = next_sum[PW-1:0];
            tag_ra  = next_sum[PW-1:0];
            if (next_sum >= SW'(RING_WORDS)) begin
               rp_in    = '0;
               count_in = count_ff - 1'b1;
               state_in = S_EVAL;
            end else if (SW'(wp_ff) < next_sum) begin
               // The next word may be an end marker; check its kind.
               state_in = S_POP_TAG;
            end else begin
               rp_in    = next_sum[PW-1:0];
               count_in = count_ff - 1'b1;
               state_in = S_EVAL;
            end
         end
         S_POP_TAG: begin
            rp_in    = (tag_rd == '0) ? '0 : next_ff;
            count_in = count_ff - 1'b1;
            state_in = S_EVAL;
         end
         S_COMMIT: begin
            if (count_zero) begin
               rp_in = wp_ff;
            end
            slot_in  = wp_ff;
            tag_we   = 1'b1;
            tag_wa   = wp_ff;
            tag_wd   = kind_ff;
            len_we   = 1'b1;
            wp_in    = (alloc_end >= SW'(RING_WORDS)) ? '0 : alloc_end[PW-1:0];
            count_in = count_ff + 1'b1;
            state_in = S_FRONT;
         end
         S_FRONT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {total_ff, DROP_W'(dropped_ff), HELD_W'(count_ff),
                                front_out, SLOT_W'(slot_out)};
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      dropped_ff    <= dropped_in;
      type_ff       <= type_in;
      bytes_ff      <= bytes_in;
      kind_ff       <= kind_in;
      words_ff      <= words_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      next_ff       <= next_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- verif/overwriting_trace_ring_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Trace ring allocator testbench
// Sends allocate, pop and read beats through the request stream and checks
// every response beat, against fixed values for the typed steps of a short
// corner table that comes first and against an in-bench model of the ring
// otherwise; random traffic follows. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_allocator_tb
   import otra_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_WORDS = 1024;
   localparam int WORD_BYTES = 8;
   localparam int RANDOM_BEATS = 1100;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [KIND_W-1:0]   front;
      logic [HELD_W-1:0]   held;
      logic [DROP_W-1:0]   dropped;
      logic [TOTAL_W-1:0]  total;
      logic [STATUS_W-1:0] status;
   } ring_result_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0] op;
      logic [BYTES_W-1:0]    nbytes;
      logic [KIND_W-1:0]     kind;
      bit                    typed;
      ring_result_type       want;
   } ring_step_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // alloc_bytes[15:0], entry_kind[23:16]
   logic [REQ_TYPE_W-1:0] req_tuser;   // req_type[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // slot_address[9:0], front_kind[17:10], entries_held[28:18],
   // dropped_now[39:29], dropped_total[71:40]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;   // status[1:0]

   // Model of the ring.
   logic [KIND_W-1:0] kind_mem [RING_WORDS];
   int unsigned       len_mem [RING_WORDS];
   int unsigned       rd_ptr;
   int unsigned       wr_ptr;
   int unsigned       held_cnt;
   logic [31:0]       discard_cnt;

   ring_result_type ring_answer_q[$];
   ring_step_type   plan_q[$];

   int fault_cnt;
   int rsp_cnt;
   int n_alloc;
   int n_pop;
   int n_read;
   int n_reject;
   int n_wrap;
   int burst_left;

   overwriting_trace_ring_allocator #(
      .RING_WORDS(RING_WORDS),
      .WORD_BYTES(WORD_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Frees the oldest record. Landing on an end marker ahead of the write
   // point means the rest of the ring is a wrap gap, so reading restarts at 0.
   function automatic void retire_oldest();
      int unsigned next;
      next = rd_ptr + len_mem[rd_ptr];
      if (next >= RING_WORDS)
         next = 0;
      else if (wr_ptr < next && kind_mem[next] == '0)
         next = 0;
      rd_ptr = next;
      if (held_cnt > 0)
         held_cnt--;
   endfunction

   function automatic int unsigned span_in_use();
      if (held_cnt == 0)
         return 0;
      if (wr_ptr > rd_ptr)
         return wr_ptr - rd_ptr;
      return RING_WORDS - rd_ptr + wr_ptr;
   endfunction

   function automatic ring_result_type ring_predict(input logic [REQ_TYPE_W-1:0] op,
                                                    input logic [BYTES_W-1:0] nbytes,
                                                    input logic [KIND_W-1:0] kind);
      ring_result_type res;
      int unsigned  words;
      int unsigned  slot;
      int unsigned  dropped;
      logic [STATUS_W-1:0] st;
      slot = rd_ptr;
      dropped = 0;
      st = ST_OK;
      if (op == REQ_ALLOC) begin
         words = (int'(nbytes) + WORD_BYTES) / WORD_BYTES;
         if (words > RING_WORDS || kind == '0) begin
            st = ST_TOO_LARGE;
            slot = wr_ptr;
         end else begin
            if (held_cnt == 0)
               rd_ptr = wr_ptr;
            if (wr_ptr + words > RING_WORDS) begin
               n_wrap++;
               while (held_cnt > 0 && rd_ptr >= wr_ptr) begin
                  discard_cnt++;
                  dropped++;
                  retire_oldest();
               end
               if (held_cnt == 0)
                  rd_ptr = 0;
               kind_mem[wr_ptr] = '0;
               wr_ptr = 0;
            end
            while (held_cnt > 0 && RING_WORDS - span_in_use() < words) begin
               discard_cnt++;
               dropped++;
               retire_oldest();
            end
            if (held_cnt == 0)
               rd_ptr = wr_ptr;
            slot = wr_ptr;
            kind_mem[slot] = kind;
            len_mem[slot] = words;
            wr_ptr = slot + words;
            if (wr_ptr >= RING_WORDS)
               wr_ptr = 0;
            held_cnt++;
         end
      end else if (op == REQ_POP) begin
         if (held_cnt == 0)
            st = ST_EMPTY;
         else
            retire_oldest();
         slot = rd_ptr;
      end else begin
         // Reads and the unused code both report the oldest record.
         if (held_cnt == 0)
            st = ST_EMPTY;
         slot = rd_ptr;
      end
      res.slot    = slot[SLOT_W-1:0];
      res.front   = (held_cnt > 0) ? kind_mem[rd_ptr] : '0;
      res.held    = held_cnt[HELD_W-1:0];
      res.dropped = dropped[DROP_W-1:0];
      res.total   = discard_cnt;
      res.status  = st;
      return res;
   endfunction

   task automatic add_step(input logic [REQ_TYPE_W-1:0] op, input logic [BYTES_W-1:0] nbytes,
                           input logic [KIND_W-1:0] kind, input bit typed,
                           input ring_result_type want);
      plan_q.push_back('{op, nbytes, kind, typed, want});
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input ring_step_type step);
      ring_result_type pred;
      req_tvalid <= 1'b1;
      req_tuser  <= step.op;
      req_tdata  <= {step.kind, step.nbytes};
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      pred = ring_predict(step.op, step.nbytes, step.kind);
      ring_answer_q.push_back(step.typed ? step.want : pred);
      if (pred.status == ST_TOO_LARGE)
         n_reject++;
      if (step.op == REQ_ALLOC)
         n_alloc++;
      else if (step.op == REQ_POP)
         n_pop++;
      else
         n_read++;
      @(negedge clock);
   endtask

   // Sender idles between bursts; some bursts are long with no gap at all.
   task automatic sender_idle();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   function automatic ring_step_type random_step(input int bias);
      ring_step_type step;
      int         pick;
      int         alloc_pct;
      step.typed = 1'b0;
      step.want = '0;
      step.nbytes = BYTES_W'($urandom_range(0, 65535));
      step.kind = KIND_W'($urandom_range(0, 255));
      alloc_pct = (bias == 1) ? 75 : (bias == 2) ? 30 : 52;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
         step.op = REQ_ALLOC;
         pick = $urandom_range(0, 99);
         if (pick < 70)
            step.nbytes = BYTES_W'($urandom_range(0, 255));
         else if (pick < 90)
            step.nbytes = BYTES_W'($urandom_range(256, 2047));
         else if (pick < 95)
            step.nbytes = BYTES_W'($urandom_range(2048, 8191));
         else if (pick < 97)
            step.nbytes = BYTES_W'($urandom_range(8184, 8192));
         else
            step.nbytes = BYTES_W'($urandom_range(8192, 65535));
         step.kind = ($urandom_range(0, 32) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end else begin
         pick = $urandom_range(0, 99);
         step.op = (pick < 65) ? REQ_POP : (pick < 90) ? REQ_READ : REQ_UNUSED;
      end
      return step;
   endfunction

   // Response checker.
   always @(posedge clock) begin
      ring_result_type got;
      ring_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = {rsp_tdata[9:0], rsp_tdata[17:10], rsp_tdata[28:18],
                rsp_tdata[39:29], rsp_tdata[71:40], rsp_tuser};
         rsp_cnt++;
         if (ring_answer_q.size() == 0) begin
            fault_cnt++;
            if (fault_cnt <= 10)
               $display("Response beat %0d arrived with no request outstanding", rsp_cnt);
         end else begin
            want = ring_answer_q.pop_front();
            if (got.slot !== want.slot || got.front !== want.front ||
                got.held !== want.held || got.dropped !== want.dropped ||
                got.total !== want.total || got.status !== want.status) begin
               fault_cnt++;
               if (fault_cnt <= 10) begin
                  $display("Response beat %0d mismatch (expected/actual): slot %0d/%0d %s",
                           rsp_cnt, want.slot, got.slot, "front, held, dropped:");
                  $display("   front %0d/%0d held %0d/%0d dropped %0d/%0d",
                           want.front, got.front, want.held, got.held,
                           want.dropped, got.dropped);
                  $display("   total %0d/%0d status %0d/%0d",
                           want.total, got.total, want.status, got.status);
               end
            end
         end
      end
   end

   // Receiver backpressure: the pattern is picked anew at random intervals.
   initial begin
      int mode;
      int mode_left;
      int phase;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 300);
         end
         mode_left--;
         phase = (phase == 2) ? 0 : phase + 1;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (phase != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL overwriting_trace_ring_allocator");
      $finish;
   end

   initial begin
      int bias;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_ALLOC;
      fault_cnt = 0;
      rsp_cnt = 0;
      n_alloc = 0;
      n_pop = 0;
      n_read = 0;
      n_reject = 0;
      n_wrap = 0;
      burst_left = 0;
      for (int i = 0; i < RING_WORDS; i++) begin
         kind_mem[i] = '0;
         len_mem[i] = 0;
      end
      rd_ptr = 0;
      wr_ptr = 0;
      held_cnt = 0;
      discard_cnt = '0;

      // Corner table: empty ring, rejects, whole-ring record, exact fill to
      // the end, wrap with an end marker and a pop that skips over it.
      add_step(REQ_READ,   16'd0,     8'd0,   1, {10'd0, 8'd0, 11'd0, 11'd0, 32'd0, ST_EMPTY});
      add_step(REQ_POP,    16'd0,     8'd0,   1, {10'd0, 8'd0, 11'd0, 11'd0, 32'd0, ST_EMPTY});
      add_step(REQ_UNUSED, 16'd0,     8'd0,   1, {10'd0, 8'd0, 11'd0, 11'd0, 32'd0, ST_EMPTY});
      add_step(REQ_ALLOC,  16'd0,     8'd1,   1, {10'd0, 8'd1, 11'd1, 11'd0, 32'd0, ST_OK});
      add_step(REQ_ALLOC,  16'hFFFF,  8'hFF,  1,
               {10'd1, 8'd1, 11'd1, 11'd0, 32'd0, ST_TOO_LARGE});
      add_step(REQ_ALLOC,  16'd8192,  8'd5,   1,
               {10'd1, 8'd1, 11'd1, 11'd0, 32'd0, ST_TOO_LARGE});
      add_step(REQ_ALLOC,  16'd16,    8'd0,   1,
               {10'd1, 8'd1, 11'd1, 11'd0, 32'd0, ST_TOO_LARGE});
      add_step(REQ_ALLOC,  16'd8191,  8'd255, 0, '0);
      add_step(REQ_READ,   16'd0,     8'd0,   0, '0);
      add_step(REQ_POP,    16'd0,     8'd0,   0, '0);
      add_step(REQ_POP,    16'd0,     8'd0,   0, '0);
      add_step(REQ_ALLOC,  16'd7,     8'd2,   0, '0);
      add_step(REQ_ALLOC,  16'd8,     8'd3,   0, '0);
      add_step(REQ_ALLOC,  16'd4087,  8'd4,   0, '0);
      add_step(REQ_ALLOC,  16'd4079,  8'd6,   0, '0);
      add_step(REQ_ALLOC,  16'd100,   8'd7,   0, '0);
      add_step(REQ_ALLOC,  16'd8000,  8'd8,   0, '0);
      add_step(REQ_ALLOC,  16'd40,    8'd9,   0, '0);
      add_step(REQ_POP,    16'd0,     8'd0,   0, '0);
      add_step(REQ_UNUSED, 16'hFFFF,  8'hFF,  0, '0);
      add_step(REQ_POP,    16'd0,     8'd0,   0, '0);
      add_step(REQ_ALLOC,  16'h00FF,  8'h80,  0, '0);
      add_step(REQ_POP,    16'd0,     8'd0,   0, '0);
      add_step(REQ_READ,   16'd0,     8'd0,   0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         sender_idle();
         send_beat(plan_q[i]);
      end

      // Random traffic in phases that lean toward filling or draining the ring.
      bias = 0;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 150 == 0)
            bias = $urandom_range(0, 2);
         sender_idle();
         send_beat(random_step(bias));
      end
      req_tvalid <= 1'b0;

      while (ring_answer_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response beats: %0d allocates (%0d rejected), %0d pops, %0d reads.",
               rsp_cnt, n_alloc, n_reject, n_pop, n_read);
      $display("The ring wrapped %0d times and dropped %0d records; %0d failures.",
               n_wrap, discard_cnt, fault_cnt);
      if (fault_cnt == 0)
         $display("PASS overwriting_trace_ring_allocator");
      else
         $display("FAIL overwriting_trace_ring_allocator");
      $finish;
   end

endmodule
